/* rtl/core/spip_pkg.sv */
// ----------------------------------------------------------------------------
// spip_pkg: shared types and constants for the encoder speed PID block
// Widths of the datapath, register reset values and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package spip_pkg;

  // default scaling of count change to speed
  localparam int DefSpeedMult   = 6000;
  localparam int DefCountsPerRev = 374;

  typedef logic        [15:0] count_t;
  typedef logic        [15:0] speed_t;
  typedef logic signed [31:0] coef_t;
  typedef logic signed [16:0] err_t;
  typedef logic signed [47:0] acc_t;
  typedef logic signed [50:0] work_t;
  typedef logic signed [31:0] drive_t;
  typedef logic signed [32:0] mul_a_t;
  typedef logic signed [17:0] mul_b_t;
  typedef logic signed [50:0] prod_t;
  typedef logic        [1:0]  cfg_idx_t;

  // register indexes of the configuration port
  localparam cfg_idx_t CfgCoefNow     = 2'd0;
  localparam cfg_idx_t CfgCoefOneBack = 2'd1;
  localparam cfg_idx_t CfgCoefTwoBack = 2'd2;

  localparam coef_t RstCoefNow     = 32'sd327690;
  localparam coef_t RstCoefOneBack = -32'sd327670;
  localparam coef_t RstCoefTwoBack = 32'sd0;

endpackage

`default_nettype wire

/* rtl/core/spip_if.sv */
// ----------------------------------------------------------------------------
// spip_if: request, result and configuration channels
// Valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface spip_in_if;
  logic             valid;
  logic             ready;
  spip_pkg::count_t encoder_count;
  spip_pkg::speed_t target_speed;

  modport source (output valid, output encoder_count, output target_speed, input ready);
  modport sink   (input valid, input encoder_count, input target_speed, output ready);
endinterface

interface spip_out_if;
  logic             valid;
  logic             ready;
  spip_pkg::speed_t measured_speed;
  spip_pkg::drive_t drive;

  modport source (output valid, output measured_speed, output drive, input ready);
  modport sink   (input valid, input measured_speed, input drive, output ready);
endinterface

interface spip_cfg_if;
  logic               valid;
  logic               ready;
  spip_pkg::cfg_idx_t index;
  spip_pkg::coef_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/encoder_speed_incremental_pid.sv */
// Sequence: an accepted request runs four steps for the speed (scale,
//   reciprocal, back product, fix), four for the error terms through the
//   shared 33x18 multiplier, and one to clamp and commit, which waits for
//   the result channel to drain the previous result. A new request is
//   taken only when the block is back in idle.
// Reset: coefficients return to their defaults, counter and error history
//   and the accumulator clear to zero; no clearing pass, ready as reset releases.
// ----------------------------------------------------------------------------
// encoder_speed_incremental_pid: encoder speed with velocity-form PID
// Measures speed from the encoder count change and updates a saturating
// Q32.16 drive accumulator with three weighted error terms.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_speed_incremental_pid #(
  parameter int SPEED_MULT     = spip_pkg::DefSpeedMult,
  parameter int COUNTS_PER_REV = spip_pkg::DefCountsPerRev
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  spip_in_if.sink    in_i,
  spip_out_if.source out_o,
  spip_cfg_if.sink   cfg_i
);
  import spip_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SPD_MUL  = 4'd1;
  localparam logic [3:0] S_RCP_MUL  = 4'd2;
  localparam logic [3:0] S_BACK_MUL = 4'd3;
  localparam logic [3:0] S_QUOT     = 4'd4;
  localparam logic [3:0] S_MUL0     = 4'd5;
  localparam logic [3:0] S_MUL1     = 4'd6;
  localparam logic [3:0] S_MUL2     = 4'd7;
  localparam logic [3:0] S_ADD_LAST = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  logic [3:0] state_q, state_d;

  coef_t  coef_now_q, coef_one_q, coef_two_q;
  count_t last_count_q, last_count_d;
  speed_t mag_q, mag_d;
  speed_t target_q, target_d;
  speed_t spd_q, spd_d;
  logic [31:0] x_q, x_d;
  speed_t est_q, est_d;
  err_t   e0_q, e0_d, e1_q, e1_d, e2_q, e2_d;
  acc_t   acc_q, acc_d;
  work_t  work_q, work_d;

  logic   out_valid_q, out_valid_d;
  speed_t out_spd_q, out_spd_d;
  drive_t out_drive_q, out_drive_d;

  mul_a_t mul_a;
  mul_b_t mul_b;
  prod_t  prod;
  logic [16:0] div_recip;
  speed_t div_est;
  speed_t div_quot;

  count_t diff;
  logic   in_acc;
  logic   out_free;
  logic   sat_hi, sat_lo;
  acc_t   acc_sat;

  // --------------------------------------------------------------------------
  // Shared units
  // --------------------------------------------------------------------------
  spip_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // speed division: reciprocal estimate and correction around the multiplier
  spip_div #(
    .DIVISOR (COUNTS_PER_REV)
  ) u_div (
    .dividend_i (x_q),
    .prod_i     (prod),
    .est_i      (est_q),
    .recip_o    (div_recip),
    .est_o      (div_est),
    .quot_o     (div_quot)
  );

  // --------------------------------------------------------------------------
  // Handshakes: take a request only when idle; the output register lets the
  // next request in while a result still waits to be taken.
  // --------------------------------------------------------------------------
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // modular count difference, read as signed; magnitude of -32768 is 32768
  assign diff = in_i.encoder_count - last_count_q;

  // accumulator clamp: the top four bits of the wide sum must agree
  assign sat_hi  = !work_q[50] && (work_q[49:47] != 3'b000);
  assign sat_lo  = work_q[50] && (work_q[49:47] != 3'b111);
  assign acc_sat = sat_hi ? {1'b0, {47{1'b1}}} :
                   sat_lo ? {1'b1, {47{1'b0}}} : work_q[47:0];

  // multiplier operand select
  always_comb begin
    unique case (state_q)
      S_SPD_MUL: begin
        mul_a = mul_a_t'(SPEED_MULT);
        mul_b = {2'b00, mag_q};
      end
      S_RCP_MUL: begin
        // scaled count change times the reciprocal of the divisor
        mul_a = {1'b0, prod[31:0]};
        mul_b = {1'b0, div_recip};
      end
      S_BACK_MUL: begin
        // estimate times the divisor, for the remainder check
        mul_a = mul_a_t'(COUNTS_PER_REV);
        mul_b = {2'b00, div_est};
      end
      S_MUL0: begin
        mul_a = {coef_now_q[31], coef_now_q};
        mul_b = {e0_q[16], e0_q};
      end
      S_MUL1: begin
        mul_a = {coef_one_q[31], coef_one_q};
        mul_b = {e1_q[16], e1_q};
      end
      S_MUL2: begin
        mul_a = {coef_two_q[31], coef_two_q};
        mul_b = {e2_q[16], e2_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer and datapath
  always_comb begin
    state_d      = state_q;
    last_count_d = last_count_q;
    mag_d        = mag_q;
    target_d     = target_q;
    spd_d        = spd_q;
    x_d          = x_q;
    est_d        = est_q;
    e0_d         = e0_q;
    e1_d         = e1_q;
    e2_d         = e2_q;
    acc_d        = acc_q;
    work_d       = work_q;
    out_valid_d  = out_valid_q;
    out_spd_d    = out_spd_q;
    out_drive_d  = out_drive_q;

    // drop the result once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mag_d        = diff[15] ? 16'(~diff + 16'd1) : diff;
          target_d     = in_i.target_speed;
          last_count_d = in_i.encoder_count;
          state_d      = S_SPD_MUL;
        end
      end
      S_SPD_MUL: begin
        state_d = S_RCP_MUL;
      end
      S_RCP_MUL: begin
        // hold the scaled count change for the remainder check
        x_d     = prod[31:0];
        state_d = S_BACK_MUL;
      end
      S_BACK_MUL: begin
        est_d   = div_est;
        state_d = S_QUOT;
      end
      S_QUOT: begin
        spd_d   = div_quot;
        e0_d    = err_t'({1'b0, target_q}) - err_t'({1'b0, div_quot});
        state_d = S_MUL0;
      end
      S_MUL0: begin
        // start the sum from the old accumulator
        work_d  = work_t'(acc_q);
        state_d = S_MUL1;
      end
      S_MUL1: begin
        work_d  = work_q + prod;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        work_d  = work_q + prod;
        state_d = S_ADD_LAST;
      end
      S_ADD_LAST: begin
        work_d  = work_q + prod;
        state_d = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free, then commit state and result
        if (out_free) begin
          acc_d       = acc_sat;
          e2_d        = e1_q;
          e1_d        = e0_q;
          out_valid_d = 1'b1;
          out_spd_d   = spd_q;
          out_drive_d = acc_sat[47:16];
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      last_count_q <= '0;
      e1_q         <= '0;
      e2_q         <= '0;
      acc_q        <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      last_count_q <= last_count_d;
      e1_q         <= e1_d;
      e2_q         <= e2_d;
      acc_q        <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    target_q    <= target_d;
    spd_q       <= spd_d;
    x_q         <= x_d;
    est_q       <= est_d;
    e0_q        <= e0_d;
    work_q      <= work_d;
    out_spd_q   <= out_spd_d;
    out_drive_q <= out_drive_d;
  end

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_now_q <= RstCoefNow;
      coef_one_q <= RstCoefOneBack;
      coef_two_q <= RstCoefTwoBack;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgCoefNow:     coef_now_q <= cfg_i.data;
        CfgCoefOneBack: coef_one_q <= cfg_i.data;
        CfgCoefTwoBack: coef_two_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.measured_speed = out_spd_q;
  assign out_o.drive          = out_drive_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SPD_MUL))
    else $error("accepted request did not start the sequence");
  a_fin_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && out_free) |=> ((state_q == S_IDLE) && out_valid_q))
    else $error("finish state did not commit its result");
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN))
    else $error("result raised outside the finish state");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_drive_q)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

/* rtl/core/spip_mul.sv */
// ----------------------------------------------------------------------------
// spip_mul: shared signed multiplier
// 33x18 signed multiply with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module spip_mul (
  input  wire              clk_i,
  input  spip_pkg::mul_a_t a_i,
  input  spip_pkg::mul_b_t b_i,
  output spip_pkg::prod_t  p_o
);
  import spip_pkg::*;

  prod_t p_q;

  // widen both operands first so the full product is kept
  always_ff @(posedge clk_i) begin
    p_q <= prod_t'(a_i) * prod_t'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

/* rtl/core/spip_div.sv */
// ----------------------------------------------------------------------------
// spip_div: saturating divider by a constant
// Reciprocal estimate taken from the shared multiplier, one compare and
// subtract correction, result clamped to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module spip_div #(
  parameter int DIVISOR = spip_pkg::DefCountsPerRev
) (
  input  wire       [31:0] dividend_i,
  input  wire       [50:0] prod_i,
  input  wire       [15:0] est_i,
  output logic      [16:0] recip_o,
  output spip_pkg::speed_t est_o,
  output spip_pkg::speed_t quot_o
);
  import spip_pkg::*;

  // reciprocal scaled into [2^16, 2^17): below the clamp the estimate is
  // exact or one low
  localparam int          RecipShift = 16 + $clog2(DIVISOR);
  localparam logic [16:0] Recip      = 17'((64'd1 << RecipShift) / 64'(DIVISOR));
  localparam logic [31:0] DivW       = 32'(DIVISOR);
  localparam logic [32:0] SatLim     = 33'(DIVISOR) << 16;

  logic [31:0] rem;
  logic        sat;

  assign recip_o = Recip;

  // dividend times reciprocal, shifted down
  assign est_o = prod_i[RecipShift +: 16];

  // estimate times divisor: bump the estimate when a whole divisor is left
  assign sat    = ({1'b0, dividend_i} >= SatLim);
  assign rem    = dividend_i - prod_i[31:0];
  assign quot_o = sat ? '1 : ((rem >= DivW) ? est_i + 16'd1 : est_i);

endmodule

`default_nettype wire

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: regression for encoder_speed_incremental_pid
// Drives sample-tick requests and coefficient writes through valid/ready
// channels with random idling. Every result is checked field by field
// against an in-bench predictor of speed, error history and the Q32.16
// accumulator, or against an expectation typed into the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import spip_pkg::*;

  // run length and timing
  localparam int CycleLimit     = 600000;
  localparam int RandPhases     = 8;
  localparam int ReqsPerPhase   = 212;
  localparam int DrainCycles    = 48;
  localparam int LongHoldCycles = 500;
  localparam int LongHoldAfter  = 300;

  // index with no register behind it; writes to it must be dropped
  localparam cfg_idx_t CfgNoReg = 2'd3;

  // saturation bounds of the Q32.16 accumulator
  localparam longint AccMax = 64'sd140737488355327;
  localparam longint AccMin = -64'sd140737488355328;

  typedef enum logic {RowReq, RowCfg} row_kind_e;
  typedef enum int {CoefFull, CoefSmall, CoefExtreme} coef_style_e;

  typedef struct packed {
    speed_t speed;
    drive_t drive;
  } tick_result_t;

  typedef struct packed {
    row_kind_e    kind;
    cfg_idx_t     idx;
    coef_t        value;
    count_t       count;
    speed_t       target;
    logic         typed;
    tick_result_t want;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  spip_in_if  req_if ();
  spip_out_if res_if ();
  spip_cfg_if cfg_if ();

  encoder_speed_incremental_pid dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #5ns clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: coefficients as last written, plus the tick history.
  // --------------------------------------------------------------------------
  coef_t  pid_coef_now      = RstCoefNow;
  coef_t  pid_coef_one_back = RstCoefOneBack;
  coef_t  pid_coef_two_back = RstCoefTwoBack;
  count_t prev_count        = '0;
  longint err_prev1         = 0;
  longint err_prev2         = 0;
  longint drive_acc         = 0;

  // results still owed by the block, oldest first
  tick_result_t pending_results[$];
  stim_row_t    stim_table[$];

  int     mismatch_count = 0;
  int     cycle_count    = 0;
  bit     idle_off       = 1'b0;
  bit     req_held       = 1'b0;
  count_t sent_count     = '0;

  // Advance the predictor by one sample tick and return what the block owes.
  function automatic tick_result_t predict_tick(input count_t count, input speed_t target);
    count_t       count_diff;
    longint       mag;
    longint       spd;
    longint       err;
    longint       incr;
    longint       acc;
    tick_result_t res;
    // modular difference read as signed; its magnitude is the count change
    count_diff = count - prev_count;
    mag = count_diff[15] ? 64'sd65536 - longint'(count_diff) : longint'(count_diff);
    spd = mag * DefSpeedMult / DefCountsPerRev;
    if (spd > 65535) spd = 65535;
    err = longint'(target) - spd;
    incr = longint'(pid_coef_now) * err
         + longint'(pid_coef_one_back) * err_prev1
         + longint'(pid_coef_two_back) * err_prev2;
    // saturate after the whole increment is added
    acc = drive_acc + incr;
    if (acc > AccMax) acc = AccMax;
    if (acc < AccMin) acc = AccMin;
    drive_acc  = acc;
    err_prev2  = err_prev1;
    err_prev1  = err;
    prev_count = count;
    res.speed  = speed_t'(spd);
    // arithmetic shift rounds toward minus infinity
    res.drive  = drive_t'(acc >>> 16);
    return res;
  endfunction

  function automatic coef_t pick_coef(input coef_style_e style);
    case (style)
      CoefSmall: begin
        return coef_t'(int'($urandom_range(0, 2097152)) - 1048576);
      end
      CoefExtreme: begin
        case ($urandom_range(0, 2))
          0:       return 32'sh7FFFFFFF;
          1:       return 32'sh80000000;
          default: return 32'sh0;
        endcase
      end
      default: begin
        return coef_t'($urandom);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Directed table builders
  // --------------------------------------------------------------------------
  function automatic void row_req(input count_t count, input speed_t target);
    stim_row_t row;
    row        = '0;
    row.kind   = RowReq;
    row.count  = count;
    row.target = target;
    stim_table.push_back(row);
  endfunction

  function automatic void row_typed(input count_t count, input speed_t target,
                                    input speed_t speed, input drive_t drive);
    stim_row_t row;
    row            = '0;
    row.kind       = RowReq;
    row.count      = count;
    row.target     = target;
    row.typed      = 1'b1;
    row.want.speed = speed;
    row.want.drive = drive;
    stim_table.push_back(row);
  endfunction

  function automatic void row_cfg(input cfg_idx_t idx, input coef_t value);
    stim_row_t row;
    row       = '0;
    row.kind  = RowCfg;
    row.idx   = idx;
    row.value = value;
    stim_table.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Drop valid once; later calls in the same step do nothing.
  task automatic release_req();
    if (req_held) begin
      req_if.valid <= 1'b0;
      req_held = 1'b0;
    end
  endtask

  // Hold valid until the request is taken, then log what the block owes.
  // Valid stays high so that a back-to-back request needs no toggle.
  task automatic send_req(input count_t count, input speed_t target,
                          input logic typed, input tick_result_t want);
    tick_result_t pred;
    req_if.valid         <= 1'b1;
    req_if.encoder_count <= count;
    req_if.target_speed  <= target;
    req_held = 1'b1;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    // the predictor must advance even where the expectation is typed in
    pred = predict_tick(count, target);
    pending_results.push_back(typed ? want : pred);
    sent_count = count;
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 4) == 0) begin
      release_req();
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // Stop offering requests and wait until every owed result is back.
  task automatic wait_drained();
    release_req();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; valid is left high for a following write.
  task automatic write_reg(input cfg_idx_t idx, input coef_t value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CfgCoefNow:     pid_coef_now      = value;
      CfgCoefOneBack: pid_coef_one_back = value;
      CfgCoefTwoBack: pid_coef_two_back = value;
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each accepted result, stall in random bursts, and
  // once hold off for a long stretch so the block backs up into its input.
  // --------------------------------------------------------------------------
  initial begin
    int           stall_left;
    int           mode_left;
    bit           bursty;
    int           results_seen;
    bit           long_done;
    tick_result_t exp_r;
    stall_left   = 0;
    mode_left    = 0;
    bursty       = 1'b0;
    results_seen = 0;
    long_done    = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid === 1'b1 && res_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no request pending: measured_speed %0d, drive %0d",
                 res_if.measured_speed, res_if.drive);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (res_if.measured_speed !== exp_r.speed) begin
            $error("measured_speed: expected %0d, actual %0d",
                   exp_r.speed, res_if.measured_speed);
            mismatch_count++;
          end
          if (res_if.drive !== exp_r.drive) begin
            $error("drive: expected %0d, actual %0d", exp_r.drive, res_if.drive);
            mismatch_count++;
          end
        end
      end
      // random stretches, each either with bursty stalls or with none
      if (mode_left == 0) begin
        mode_left = $urandom_range(200, 800);
        bursty    = $urandom_range(0, 2) != 0;
      end
      mode_left--;
      if (!long_done && results_seen >= LongHoldAfter) begin
        long_done  = 1'b1;
        stall_left = LongHoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (bursty && !idle_off && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t row;
    bit        in_cfg;
    bit        sender_bursty;
    int        kind;
    count_t    cnt;
    count_t    delta;
    speed_t    tgt;

    in_cfg        = 1'b0;
    sender_bursty = 1'b1;

    // hold every input at a known value from the start
    req_if.valid         <= 1'b0;
    req_if.encoder_count <= '0;
    req_if.target_speed  <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CfgCoefNow;
    cfg_if.data          <= '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults: zero history gives zero out, then the count change
    // edges: single steps both ways, wrap across zero, the half-range
    // step whose magnitude is 32768, and the last unsaturated speed step.
    row_typed(16'h0000, 16'h0000, 16'd0, 32'sd0);
    row_req(16'h0001, 16'h0000);
    row_req(16'h0000, 16'hFFFF);
    row_req(16'h8000, 16'hFFFF);
    row_req(16'h0000, 16'h0000);
    row_req(16'hFFFF, 16'hFFFF);
    row_req(16'h7FFF, 16'h1234);
    row_req(16'h8000, 16'h8000);
    row_req(16'h8FF5, 16'hFFFF);   // step 4085: just under saturation
    row_req(16'h9FEB, 16'h0000);   // step 4086: speed saturates
    row_req(16'h9FEB, 16'hFFFF);
    // a write to the unused index must change nothing
    row_cfg(CfgNoReg, 32'shDEADBEEF);
    row_req(16'h9FEB, 16'hFFFF);
    // largest positive weights drive the accumulator into its upper bound
    row_cfg(CfgCoefNow,     32'sh7FFFFFFF);
    row_cfg(CfgCoefOneBack, 32'sh7FFFFFFF);
    row_cfg(CfgCoefTwoBack, 32'sh7FFFFFFF);
    row_req(16'h9FEB, 16'hFFFF);
    row_req(16'h9FEB, 16'hFFFF);
    row_typed(16'h9FEB, 16'hFFFF, 16'd0, 32'sh7FFFFFFF);
    row_typed(16'h9FEB, 16'hFFFF, 16'd0, 32'sh7FFFFFFF);
    // most negative weights slam it into the lower bound at once
    row_cfg(CfgCoefNow,     32'sh80000000);
    row_cfg(CfgCoefOneBack, 32'sh80000000);
    row_cfg(CfgCoefTwoBack, 32'sh80000000);
    row_typed(16'h9FEB, 16'hFFFF, 16'd0, 32'sh80000000);
    row_typed(16'h9FEB, 16'hFFFF, 16'd0, 32'sh80000000);
    row_typed(16'h9FEB, 16'hFFFF, 16'd0, 32'sh80000000);
    // zero weights freeze the accumulator; only the speed moves
    row_cfg(CfgCoefNow,     32'sh0);
    row_cfg(CfgCoefOneBack, 32'sh0);
    row_cfg(CfgCoefTwoBack, 32'sh0);
    row_typed(16'hA04F, 16'h0000, 16'd1604, 32'sh80000000);
    row_typed(16'h9FEB, 16'h0000, 16'd1604, 32'sh80000000);
    // back to the defaults
    row_cfg(CfgCoefNow,     RstCoefNow);
    row_cfg(CfgCoefOneBack, RstCoefOneBack);
    row_cfg(CfgCoefTwoBack, RstCoefTwoBack);
    row_req(16'h0000, 16'h0400);
    row_req(16'h0010, 16'h0100);

    // Walk the table; a register write waits until the block is idle.
    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == RowCfg) begin
        if (!in_cfg) wait_drained();
        write_reg(row.idx, row.value);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          cfg_if.valid <= 1'b0;
          in_cfg = 1'b0;
        end
        maybe_idle(sender_bursty);
        send_req(row.count, row.target, row.typed, row.want);
      end
    end

    // Random phases, each under its own coefficient setting.
    for (int phase = 0; phase < RandPhases; phase++) begin
      wait_drained();
      case (phase)
        0, RandPhases - 1: begin
          write_reg(CfgCoefNow,     RstCoefNow);
          write_reg(CfgCoefOneBack, RstCoefOneBack);
          write_reg(CfgCoefTwoBack, RstCoefTwoBack);
        end
        1: begin
          write_reg(CfgCoefNow,     pick_coef(CoefSmall));
          write_reg(CfgCoefOneBack, pick_coef(CoefSmall));
          write_reg(CfgCoefTwoBack, pick_coef(CoefSmall));
        end
        2: begin
          write_reg(CfgCoefNow,     32'sh7FFFFFFF);
          write_reg(CfgCoefOneBack, 32'sh7FFFFFFF);
          write_reg(CfgCoefTwoBack, 32'sh7FFFFFFF);
        end
        3: begin
          // mixed signs keep the accumulator swinging between the bounds
          write_reg(CfgCoefNow,     32'sh80000000);
          write_reg(CfgCoefOneBack, 32'sh7FFFFFFF);
          write_reg(CfgCoefTwoBack, 32'sh80000000);
        end
        default: begin
          write_reg(CfgCoefNow,     pick_coef(coef_style_e'($urandom_range(0, 2))));
          write_reg(CfgCoefOneBack, pick_coef(coef_style_e'($urandom_range(0, 2))));
          write_reg(CfgCoefTwoBack, pick_coef(coef_style_e'($urandom_range(0, 2))));
          if ($urandom_range(0, 1) == 1) write_reg(CfgNoReg, coef_t'($urandom));
        end
      endcase
      cfg_if.valid <= 1'b0;

      // no idling on either side in the closing phase
      if (phase == RandPhases - 1) idle_off = 1'b1;
      sender_bursty = !idle_off && $urandom_range(0, 3) != 0;

      for (int n = 0; n < ReqsPerPhase; n++) begin
        // once, pause the sender until every result has come back
        if (phase == 3 && n == ReqsPerPhase / 2) wait_drained();
        maybe_idle(sender_bursty);
        kind = $urandom_range(0, 9);
        case (kind)
          0: begin
            // noise: any count, any target
            cnt = count_t'($urandom);
            tgt = speed_t'($urandom);
          end
          8: begin
            // jump of about half the counter range
            cnt = sent_count + 16'h8000 + count_t'($urandom_range(0, 8)) - 16'd4;
            tgt = speed_t'($urandom);
          end
          9: begin
            // motor standing still
            cnt = sent_count;
            tgt = speed_t'($urandom);
          end
          default: begin
            // plausible motion: a modest count change either way
            delta = count_t'($urandom_range(0, 4200));
            cnt   = ($urandom_range(0, 1) == 1) ? sent_count + delta : sent_count - delta;
            tgt   = ($urandom_range(0, 7) == 0) ? speed_t'($urandom)
                                                : speed_t'($urandom_range(0, 20000));
          end
        endcase
        send_req(cnt, tgt, 1'b0, '0);
      end
    end

    // let the last results arrive, then watch for stray ones
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
